// ===== rtl/strm_pkg.sv =====
// Shared constants and types for the sparse-table range-minimum block.
`default_nettype none
package strm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;

    // Index, count and level widths
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W = $clog2(LEVELS + 1);
    localparam int CMP_W = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;

    // Table memory geometry: one row of MAX_ELEMENTS words for each level
    localparam int MEM_DEPTH = LEVELS * MAX_ELEMENTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;

endpackage
`default_nettype wire

// ===== rtl/sparse_table_range_min.sv =====
// Sparse-table range-minimum block: element load, table build and query.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | to block  | i_valid / o_ready  | action, element_value, last_element,
//          |           |                    | left_index, right_index
//  out     | from block| o_valid / i_ready  | range_minimum, range_error
//
// A load is one write into the table memory. A query reads two table words, one
// after the other, through the single read port of the memory; a query flagged as
// an error skips the reads and goes straight to the output state.
// The load marked last runs the build: one level check per level, then two reads
// and one write-back per table entry, walking every level that fits.
// Reset clears the count, the built flag, the sequencer and the output valid flag;
// the table memory is not cleared. A result waits in the output register; loads go
// on meanwhile, and a query holds its last cycle while that register stays full.
`default_nettype none
module sparse_table_range_min (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_action,
    input  wire logic signed [31:0]            i_element_value,
    input  wire logic                          i_last_element,
    input  wire logic [9:0]                    i_left_index,
    input  wire logic [9:0]                    i_right_index,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [31:0]                 o_range_minimum,
    output logic                               o_range_error
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QB   = 3'd1;
    localparam logic [2:0] S_QOUT = 3'd2;
    localparam logic [2:0] S_BCHK = 3'd3;
    localparam logic [2:0] S_BRA  = 3'd4;
    localparam logic [2:0] S_BRB  = 3'd5;
    localparam logic [2:0] S_BWR  = 3'd6;

    function automatic strm_pkg::t_addr mem_addr(
        input logic [strm_pkg::LVL_W-1:0] lvl,
        input logic [strm_pkg::IDX_W-1:0] idx
    );
        mem_addr = strm_pkg::ADDR_W'(lvl) * strm_pkg::ADDR_W'(strm_pkg::MAX_ELEMENTS)
                 + strm_pkg::ADDR_W'(idx);
    endfunction

    // Highest set bit of the span length, clamped to the top level
    function automatic logic [strm_pkg::LVL_W-1:0] floor_log2(
        input logic [strm_pkg::CNT_W-1:0] len
    );
        logic [strm_pkg::LVL_W-1:0] k;
        k = '0;
        for (int b = 0; b < strm_pkg::CNT_W; b++) begin
            if (len[b]) begin
                k = (b > strm_pkg::LEVELS - 1) ? strm_pkg::LVL_W'(strm_pkg::LEVELS - 1)
                                               : strm_pkg::LVL_W'(b);
            end
        end
        floor_log2 = k;
    endfunction

    // Table memory
    strm_pkg::t_word mem [0:strm_pkg::MEM_DEPTH-1];
    strm_pkg::t_word r_rdata;
    logic            w_re;
    logic            w_we;
    strm_pkg::t_addr w_raddr;
    strm_pkg::t_addr w_waddr;
    strm_pkg::t_word w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // Control and datapath registers
    logic [2:0]                 r_state, n_state;
    logic [strm_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_built, n_built;
    logic [strm_pkg::LVL_W-1:0] r_lvl, n_lvl;
    logic [strm_pkg::IDX_W-1:0] r_i, n_i;
    strm_pkg::t_addr            r_addr_b, n_addr_b;
    logic                       r_qerr, n_qerr;
    strm_pkg::t_word            r_a, n_a;
    logic                       r_out_valid, n_out_valid;
    strm_pkg::t_word            r_out_min, n_out_min;
    logic                       r_out_err, n_out_err;

    logic                       w_slot_free;
    logic                       w_accept;
    logic [strm_pkg::CNT_W-1:0] w_eff_count;
    logic [strm_pkg::CNT_W-1:0] w_len;
    logic [strm_pkg::LVL_W-1:0] w_k;
    logic [strm_pkg::CNT_W-1:0] w_second;
    logic                       w_q_err;
    logic [strm_pkg::CMP_W-1:0] w_span;
    logic [strm_pkg::CMP_W-1:0] w_half;
    strm_pkg::t_word            w_min;

    assign w_slot_free = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE) || ((r_state == S_QOUT) && w_slot_free);
    assign w_accept    = i_valid && o_ready;

    assign w_eff_count = r_built ? '0 : r_count;
    assign w_len       = strm_pkg::CNT_W'(i_right_index) - strm_pkg::CNT_W'(i_left_index)
                       + strm_pkg::CNT_W'(1);
    assign w_k         = floor_log2(w_len);
    assign w_second    = strm_pkg::CNT_W'(i_right_index) + strm_pkg::CNT_W'(1)
                       - (strm_pkg::CNT_W'(1) << w_k);
    assign w_q_err     = !r_built || (i_left_index > i_right_index)
                       || (strm_pkg::CNT_W'(i_right_index) >= r_count);

    assign w_span = strm_pkg::CMP_W'(1) << r_lvl;
    assign w_half = strm_pkg::CMP_W'(1) << (r_lvl - strm_pkg::LVL_W'(1));
    assign w_min  = (r_a <= r_rdata) ? r_a : r_rdata;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_built     = r_built;
        n_lvl       = r_lvl;
        n_i         = r_i;
        n_addr_b    = r_addr_b;
        n_qerr      = r_qerr;
        n_a         = r_a;
        n_out_valid = r_out_valid && !i_ready;
        n_out_min   = r_out_min;
        n_out_err   = r_out_err;
        w_re        = 1'b0;
        w_we        = 1'b0;
        w_raddr     = mem_addr(r_lvl, r_i);
        w_waddr     = mem_addr(r_lvl, r_i);
        w_wdata     = w_min;

        unique case (r_state)
            S_IDLE: begin
            end
            S_QB: begin
                // Second read goes out while the first word lands
                w_re    = 1'b1;
                w_raddr = r_addr_b;
                n_a     = r_rdata;
                n_state = S_QOUT;
            end
            S_QOUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_min   = r_qerr ? '0 : w_min;
                    n_out_err   = r_qerr;
                    n_state     = S_IDLE;
                end
            end
            S_BCHK: begin
                if ((r_lvl < strm_pkg::LVL_W'(strm_pkg::LEVELS))
                        && (w_span <= strm_pkg::CMP_W'(r_count))) begin
                    n_i     = '0;
                    n_state = S_BRA;
                end else begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BRA: begin
                w_re    = 1'b1;
                w_raddr = mem_addr(r_lvl - strm_pkg::LVL_W'(1), r_i);
                n_state = S_BRB;
            end
            S_BRB: begin
                w_re    = 1'b1;
                w_raddr = mem_addr(r_lvl - strm_pkg::LVL_W'(1),
                                   r_i + strm_pkg::IDX_W'(w_half));
                n_a     = r_rdata;
                n_state = S_BWR;
            end
            S_BWR: begin
                w_we = 1'b1;
                if (strm_pkg::CMP_W'(r_i) + w_span + strm_pkg::CMP_W'(1)
                        <= strm_pkg::CMP_W'(r_count)) begin
                    n_i     = r_i + strm_pkg::IDX_W'(1);
                    n_state = S_BRA;
                end else begin
                    // Level done: advance
                    n_lvl   = r_lvl + strm_pkg::LVL_W'(1);
                    n_state = S_BCHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_accept) begin
            if (!i_action) begin
                // Load beat: a load after a build starts a new array
                n_built = 1'b0;
                n_count = w_eff_count;
                if (w_eff_count < strm_pkg::CNT_W'(strm_pkg::MAX_ELEMENTS)) begin
                    w_we    = 1'b1;
                    w_waddr = mem_addr('0, strm_pkg::IDX_W'(w_eff_count));
                    w_wdata = i_element_value;
                    n_count = w_eff_count + strm_pkg::CNT_W'(1);
                end
                if (i_last_element) begin
                    n_lvl   = strm_pkg::LVL_W'(1);
                    n_state = S_BCHK;
                end else begin
                    n_state = S_IDLE;
                end
            end else begin
                n_qerr = w_q_err;
                if (w_q_err) begin
                    n_state = S_QOUT;
                end else begin
                    w_re     = 1'b1;
                    w_raddr  = mem_addr(w_k, strm_pkg::IDX_W'(i_left_index));
                    n_addr_b = mem_addr(w_k, strm_pkg::IDX_W'(w_second));
                    n_state  = S_QB;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_i       <= n_i;
        r_addr_b  <= n_addr_b;
        r_qerr    <= n_qerr;
        r_a       <= n_a;
        r_out_min <= n_out_min;
        r_out_err <= n_out_err;
    end

    assign o_valid         = r_out_valid;
    assign o_range_minimum = r_out_min;
    assign o_range_error   = r_out_err;

    // Checks
    a_no_accept_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BCHK) || (r_state == S_BRA) || (r_state == S_BRB)
            || (r_state == S_BWR)) |-> !o_ready)
        else $error("input taken during table build");

    a_error_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_range_minimum == '0))
        else $error("error result with non-zero minimum");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= strm_pkg::CNT_W'(strm_pkg::MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_last_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_action && i_last_element)
            |=> ((r_state == S_BCHK) && !r_built))
        else $error("last element did not start a build");

    a_bad_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_action && !r_built) |=> ((r_state == S_QOUT) && r_qerr))
        else $error("query before build not flagged");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the sparse-table range-minimum block.

typedef enum bit {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
} t_action;

// Keeps its own copy of the array and table, and the answers still owed by the block
class span_min_tracker;
    typedef struct packed {
        logic signed [31:0] minimum;
        logic               fault;
    } t_answer;

    strm_pkg::t_word level_rows [strm_pkg::LEVELS][strm_pkg::MAX_ELEMENTS];
    int unsigned     held;
    bit              built;
    t_answer         pending_answers [$];
    int              faults;
    int              answers_seen;

    function new();
        held         = 0;
        built        = 1'b0;
        faults       = 0;
        answers_seen = 0;
    endfunction

    function strm_pkg::t_word smaller(strm_pkg::t_word a, strm_pkg::t_word b);
        return (a <= b) ? a : b;
    endfunction

    function void build_levels();
        int unsigned half;
        for (int unsigned lvl = 1;
             lvl < strm_pkg::LEVELS && (32'd1 << lvl) <= held; lvl++) begin
            half = 32'd1 << (lvl - 1);
            for (int unsigned i = 0; i + (32'd1 << lvl) <= held; i++)
                level_rows[lvl][i] = smaller(level_rows[lvl-1][i], level_rows[lvl-1][i+half]);
        end
        built = 1'b1;
    endfunction

    function void note_beat(t_action act, strm_pkg::t_word value, bit last,
                            logic [9:0] lo, logic [9:0] hi);
        t_answer     ans;
        int unsigned span;
        int unsigned k;
        int unsigned tail;
        if (act == ACT_LOAD) begin
            if (built) begin
                held  = 0;
                built = 1'b0;
            end
            // drop elements beyond capacity, but still honour the last mark
            if (held < strm_pkg::MAX_ELEMENTS) begin
                level_rows[0][held] = value;
                held++;
            end
            if (last)
                build_levels();
        end else begin
            if (!built || lo > hi || hi >= held) begin
                ans.minimum = '0;
                ans.fault   = 1'b1;
            end else begin
                span = 32'(hi) - 32'(lo) + 1;
                k    = 0;
                while ((32'd2 << k) <= span)
                    k++;
                if (k > strm_pkg::LEVELS - 1)
                    k = strm_pkg::LEVELS - 1;
                tail        = 32'(hi) + 1 - (32'd1 << k);
                ans.minimum = smaller(level_rows[k][lo], level_rows[k][tail]);
                ans.fault   = 1'b0;
            end
            pending_answers = {pending_answers, ans};
        end
    endfunction

    task report(string what);
        faults++;
        $display("CHECK FAILED: %s", what);
    endtask

    task check_answer(strm_pkg::t_word got_min, logic got_fault);
        t_answer want;
        answers_seen++;
        if (pending_answers.size() == 0) begin
            report($sformatf("answer %0d arrived with none owed (min=%0d err=%b)",
                             answers_seen, got_min, got_fault));
            return;
        end
        want = pending_answers.pop_front();
        if (got_fault !== want.fault)
            report($sformatf("answer %0d: range_error %b, wanted %b",
                             answers_seen, got_fault, want.fault));
        if (got_min !== want.minimum)
            report($sformatf("answer %0d: range_minimum %0d, wanted %0d",
                             answers_seen, got_min, want.minimum));
    endtask

    function int outstanding();
        return pending_answers.size();
    endfunction
endclass

module testbench;

    localparam int ITEM_TARGET    = 1750;
    localparam int CALM_FROM      = ITEM_TARGET * 85 / 100;
    localparam int SQUEEZE_AFTER  = 40;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_action;
    logic signed [31:0] i_element_value;
    logic               i_last_element;
    logic [9:0]         i_left_index;
    logic [9:0]         i_right_index;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_range_minimum;
    logic               o_range_error;

    span_min_tracker book;
    int              items_sent   = 0;
    int              answers_got  = 0;
    int              cycles       = 0;
    int              gap_odds     = 0;
    bit              calm         = 1'b0;
    bit              squeeze_done = 1'b0;
    bit              full_done    = 1'b0;

    sparse_table_range_min dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_element_value (i_element_value),
        .i_last_element  (i_last_element),
        .i_left_index    (i_left_index),
        .i_right_index   (i_right_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_range_minimum (o_range_minimum),
        .o_range_error   (o_range_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check outgoing beats before booking incoming ones: an answer never belongs to a
    // query taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                book.check_answer(o_range_minimum, o_range_error);
                answers_got++;
            end
            if (i_valid && o_ready)
                book.note_beat(t_action'(i_action), i_element_value, i_last_element,
                               i_left_index, i_right_index);
        end
    end

    // Receiver: random stalls, long open stretches, and one long hold-off
    initial begin
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!squeeze_done && answers_got >= SQUEEZE_AFTER) begin
                squeeze_done = 1'b1;
                i_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 16))
                    @(posedge i_clk);
            end
        end
    end

    function automatic strm_pkg::t_word pick_value(int mode);
        case (mode)
            1: return strm_pkg::t_word'(int'($urandom_range(0, 16)) - 8);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return strm_pkg::t_word'($urandom);
        endcase
    endfunction

    // Called just after an edge; returns just after the edge that takes the beat
    task automatic send_item(t_action act, strm_pkg::t_word value, bit last,
                             logic [9:0] lo, logic [9:0] hi);
        if (!calm && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_element_value <= value;
        i_last_element  <= last;
        i_left_index    <= lo;
        i_right_index   <= hi;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (items_sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    // n is the element count the table holds; zero means no useful span
    task automatic send_query(int unsigned n);
        int unsigned kind;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        kind = $urandom_range(0, 99);
        if (n == 0 || kind >= 92) begin
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(0, 1023);
        end else if (kind < 70) begin
            lo = $urandom_range(0, n - 1);
            hi = $urandom_range(lo, n - 1);
        end else if (kind < 78) begin
            // exact power-of-two span: both windows coincide
            k = $urandom_range(0, strm_pkg::LEVELS - 1);
            while ((32'd1 << k) > n)
                k--;
            lo = $urandom_range(0, n - (32'd1 << k));
            hi = lo + (32'd1 << k) - 1;
        end else if (kind < 85) begin
            hi = $urandom_range((n > 1023) ? 1023 : n, 1023);
            lo = $urandom_range(0, hi);
        end else begin
            hi = $urandom_range(0, 1022);
            lo = $urandom_range(hi + 1, 1023);
        end
        send_item(ACT_QUERY, strm_pkg::t_word'($urandom), 1'($urandom), 10'(lo), 10'(hi));
    endtask

    task automatic run_array(int unsigned loads, int unsigned queries);
        int          mode;
        int unsigned n;
        mode = $urandom_range(0, 3);
        for (int unsigned i = 0; i < loads; i++) begin
            // a query part-way through loading sees no table yet
            if (i > 0 && $urandom_range(0, 29) == 0)
                send_query(0);
            if (loads > 200)
                mode = $urandom_range(0, 3);
            send_item(ACT_LOAD, pick_value(mode), i == loads - 1,
                      10'($urandom), 10'($urandom));
        end
        n = (loads > strm_pkg::MAX_ELEMENTS) ? strm_pkg::MAX_ELEMENTS : loads;
        repeat (queries) send_query(n);
    endtask

    initial begin
        int unsigned n;
        book = new();
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_action        <= ACT_LOAD;
        i_element_value <= '0;
        i_last_element  <= 1'b0;
        i_left_index    <= '0;
        i_right_index   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        gap_odds = 2;

        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd0);
        send_item(ACT_LOAD, 32'sh7FFF_FFFF, 1'b0, 10'h3FF, 10'h3FF);
        send_item(ACT_LOAD, 32'sh8000_0000, 1'b0, 10'h000, 10'h3FF);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd1);
        send_item(ACT_LOAD, -32'sd1, 1'b0, 10'd0, 10'd0);
        send_item(ACT_LOAD, 32'sd0, 1'b0, 10'd0, 10'd0);
        send_item(ACT_LOAD, 32'sd1, 1'b1, 10'd0, 10'd0);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd4);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd0);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd2, 10'd4);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd3, 10'd4);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd1, 10'd1);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd4, 10'd3);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd5);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd1023, 10'd1023);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd1023, 10'd0);
        send_item(ACT_QUERY, 32'sh5A5A_5A5A, 1'b1, 10'd0, 10'd3);
        // load after a build: a fresh one-element array
        send_item(ACT_LOAD, 32'sd42, 1'b1, 10'd0, 10'd0);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd0);
        send_item(ACT_QUERY, 32'sd0, 1'b0, 10'd0, 10'd1);

        while (items_sent < ITEM_TARGET) begin
            gap_odds = $urandom_range(0, 3);
            if (!full_done && items_sent >= 150) begin
                // full capacity plus a few dropped loads, last mark on a dropped one
                full_done = 1'b1;
                run_array(strm_pkg::MAX_ELEMENTS + $urandom_range(1, 3), 70);
                send_item(ACT_QUERY, strm_pkg::t_word'($urandom), 1'b0, 10'd0, 10'd1023);
                send_item(ACT_QUERY, strm_pkg::t_word'($urandom), 1'b0, 10'd1023, 10'd1023);
                send_item(ACT_QUERY, strm_pkg::t_word'($urandom), 1'b0, 10'd1, 10'd1023);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 100)
                                                : $urandom_range(1, 32);
                run_array(n, $urandom_range(2, 30));
            end
        end
        i_valid <= 1'b0;

        while (book.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.outstanding() != 0)
            book.report($sformatf("%0d answers never arrived", book.outstanding()));
        if (book.faults == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
